FILE: rtl/tmdd_pkg.sv
// ----------------------------------------------------------------------------
// tmdd_pkg: shared types, constants and priority encoders for the decoder
// Holds the block geometry of the tree-masked frame-delta stream.
// ----------------------------------------------------------------------------
package tmdd_pkg;

    // Number of four-line blocks covered by the top mask (1..16)
    localparam int TOP_BLOCKS = 13;

    localparam int BYTE_W   = 8;
    localparam int TOP_W    = 16;
    localparam int TOP_IDX_W = 4;
    localparam int SUB_IDX_W = 3;
    localparam int PIX_IDX_W = 2;
    localparam int COORD_W  = 6;
    localparam int LCNT_W   = 7;

    localparam logic [LCNT_W-1:0] LINE_COUNT_RST = LCNT_W'(51);

    // Top mask bits that map to real blocks
    localparam logic [TOP_W-1:0] TOP_USED = TOP_W'((32'h1 << TOP_BLOCKS) - 32'h1);

    typedef logic [BYTE_W-1:0] t_byte;

    typedef struct packed {
        logic                 found;
        logic [TOP_IDX_W-1:0] idx;
    } t_seek_top;

    typedef struct packed {
        logic                 found;
        logic [SUB_IDX_W-1:0] idx;
    } t_seek_sub;

    // Lowest set, used top bit at or above 'from'
    function automatic t_seek_top seek_top(input logic [TOP_W-1:0] mask,
                                           input logic [TOP_IDX_W:0] from);
        logic [TOP_W-1:0] m;
        t_seek_top        r;
        m       = mask & TOP_USED & ({TOP_W{1'b1}} << from);
        r.found = |m;
        r.idx   = '0;
        for (int i = TOP_W - 1; i >= 0; i--) begin
            if (m[i]) begin
                r.idx = TOP_IDX_W'(i);
            end
        end
        return r;
    endfunction

    // Lowest set bit of a byte mask at or above 'from'
    function automatic t_seek_sub seek_sub(input t_byte mask,
                                           input logic [SUB_IDX_W:0] from);
        t_byte     m;
        t_seek_sub r;
        m       = mask & ({BYTE_W{1'b1}} << from);
        r.found = |m;
        r.idx   = '0;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            if (m[i]) begin
                r.idx = SUB_IDX_W'(i);
            end
        end
        return r;
    endfunction

endpackage

FILE: rtl/tree_mask_delta_decoder.sv
// ----------------------------------------------------------------------------
// tree_mask_delta_decoder: tree-masked frame-delta stream to pixel writes
// Latency: a result word is registered when its stream byte is accepted.
// Throughput: one byte per cycle while the result channel does not stall; the mask seek is one priority encode.
// Reset: synchronous, active low; decoder waits for a top mask, line count 51.
// ----------------------------------------------------------------------------
module tree_mask_delta_decoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // stream byte channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  tmdd_pkg::t_byte                   i_stream_byte,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_pixel_valid,
    output logic [tmdd_pkg::COORD_W-1:0]      o_pixel_column,
    output logic [tmdd_pkg::COORD_W-1:0]      o_pixel_line,
    output tmdd_pkg::t_byte                   o_pixel_value,
    output logic                              o_frame_done,
    // line count register write
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tmdd_pkg::LCNT_W-1:0]       i_cfg_data
);
    import tmdd_pkg::*;

    // Decoder phase: which kind of byte the stream holds next
    typedef enum logic [2:0] {
        PH_TOP0 = 3'd0,   // low byte of top mask
        PH_TOP1 = 3'd1,   // high byte of top mask
        PH_MID  = 3'd2,   // mid mask of the current block
        PH_LEAF = 3'd3,   // leaf mask of the current half-line
        PH_PIX  = 3'd4    // one of four pixel bytes of the current group
    } t_phase_e;

    // Decode state
    t_phase_e               r_phase,      n_phase;
    logic [TOP_W-1:0]       r_top_mask,   n_top_mask;
    logic [TOP_IDX_W-1:0]   r_top_index,  n_top_index;
    t_byte                  r_mid_mask,   n_mid_mask;
    logic [SUB_IDX_W-1:0]   r_mid_index,  n_mid_index;
    t_byte                  r_leaf_mask,  n_leaf_mask;
    logic [SUB_IDX_W-1:0]   r_leaf_index, n_leaf_index;
    logic [PIX_IDX_W-1:0]   r_pix_index,  n_pix_index;
    logic [LCNT_W-1:0]      r_line_count;

    // Result register
    logic                   r_out_valid;
    logic                   r_pix_valid,  n_pix_valid;
    logic [COORD_W-1:0]     r_pix_col,    n_pix_col;
    logic [COORD_W-1:0]     r_pix_line,   n_pix_line;
    t_byte                  r_pix_val,    n_pix_val;
    logic                   r_done,       n_done;

    logic                   in_accept;
    logic [COORD_W-1:0]     pix_line;
    logic [COORD_W-1:0]     pix_col;

    // Priority encoders. The "next" seeks resume one past the current node;
    // the byte seek serves both a fresh mid mask and a fresh leaf mask.
    t_seek_top              s_top_first;
    t_seek_top              s_top_next;
    t_seek_sub              s_byte_first;
    t_seek_sub              s_mid_next;
    t_seek_sub              s_leaf_next;

    // The result register drains whenever the sink takes it, so a new byte
    // is taken in the same cycle as the old result leaves.
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_accept   = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign s_top_first  = seek_top({i_stream_byte, r_top_mask[BYTE_W-1:0]}, '0);
    assign s_top_next   = seek_top(r_top_mask, {1'b0, r_top_index} + 1'b1);
    assign s_byte_first = seek_sub(i_stream_byte, '0);
    assign s_mid_next   = seek_sub(r_mid_mask, {1'b0, r_mid_index} + 1'b1);
    assign s_leaf_next  = seek_sub(r_leaf_mask, {1'b0, r_leaf_index} + 1'b1);

    // Pixel position: line = 4*block + half-line/2,
    // column = 32*(half-line odd) + 4*group + pixel
    assign pix_line = {r_top_index, r_mid_index[SUB_IDX_W-1:1]};
    assign pix_col  = {r_mid_index[0], r_leaf_index, r_pix_index};

    always_comb begin
        n_phase      = r_phase;
        n_top_mask   = r_top_mask;
        n_top_index  = r_top_index;
        n_mid_mask   = r_mid_mask;
        n_mid_index  = r_mid_index;
        n_leaf_mask  = r_leaf_mask;
        n_leaf_index = r_leaf_index;
        n_pix_index  = r_pix_index;
        n_pix_valid  = 1'b0;
        n_pix_col    = '0;
        n_pix_line   = '0;
        n_pix_val    = '0;
        n_done       = 1'b0;

        unique case (r_phase)
            PH_TOP1: begin
                n_top_mask = {i_stream_byte, r_top_mask[BYTE_W-1:0]};
                if (s_top_first.found) begin
                    n_top_index = s_top_first.idx;
                    n_phase     = PH_MID;
                end else begin
                    // empty frame: ends on the second top mask byte
                    n_phase = PH_TOP0;
                    n_done  = 1'b1;
                end
            end
            PH_MID: begin
                n_mid_mask = i_stream_byte;
                if (s_byte_first.found) begin
                    n_mid_index = s_byte_first.idx;
                    n_phase     = PH_LEAF;
                end else if (s_top_next.found) begin
                    n_top_index = s_top_next.idx;
                    n_phase     = PH_MID;
                end else begin
                    n_phase = PH_TOP0;
                    n_done  = 1'b1;
                end
            end
            PH_LEAF: begin
                n_leaf_mask = i_stream_byte;
                if (s_byte_first.found) begin
                    n_leaf_index = s_byte_first.idx;
                    n_pix_index  = '0;
                    n_phase      = PH_PIX;
                end else if (s_mid_next.found) begin
                    n_mid_index = s_mid_next.idx;
                    n_phase     = PH_LEAF;
                end else if (s_top_next.found) begin
                    n_top_index = s_top_next.idx;
                    n_phase     = PH_MID;
                end else begin
                    n_phase = PH_TOP0;
                    n_done  = 1'b1;
                end
            end
            PH_PIX: begin
                // write only lines inside the configured frame height
                if ({1'b0, pix_line} < r_line_count) begin
                    n_pix_valid = 1'b1;
                    n_pix_col   = pix_col;
                    n_pix_line  = pix_line;
                    n_pix_val   = i_stream_byte;
                end
                if (&r_pix_index) begin
                    // group finished: advance to the next marked node
                    if (s_leaf_next.found) begin
                        n_leaf_index = s_leaf_next.idx;
                        n_pix_index  = '0;
                        n_phase      = PH_PIX;
                    end else if (s_mid_next.found) begin
                        n_mid_index = s_mid_next.idx;
                        n_phase     = PH_LEAF;
                    end else if (s_top_next.found) begin
                        n_top_index = s_top_next.idx;
                        n_phase     = PH_MID;
                    end else begin
                        n_phase = PH_TOP0;
                        n_done  = 1'b1;
                    end
                end else begin
                    n_pix_index = r_pix_index + 1'b1;
                end
            end
            default: begin
                // first top mask byte; clears the high half
                n_top_mask = {{(TOP_W-BYTE_W){1'b0}}, i_stream_byte};
                n_phase    = PH_TOP1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_TOP0;
            r_top_mask   <= '0;
            r_top_index  <= '0;
            r_mid_mask   <= '0;
            r_mid_index  <= '0;
            r_leaf_mask  <= '0;
            r_leaf_index <= '0;
            r_pix_index  <= '0;
            r_line_count <= LINE_COUNT_RST;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_line_count <= i_cfg_data;
            end
            if (in_accept) begin
                r_phase      <= n_phase;
                r_top_mask   <= n_top_mask;
                r_top_index  <= n_top_index;
                r_mid_mask   <= n_mid_mask;
                r_mid_index  <= n_mid_index;
                r_leaf_mask  <= n_leaf_mask;
                r_leaf_index <= n_leaf_index;
                r_pix_index  <= n_pix_index;
                // a word is produced only for a pixel write or a frame end
                r_out_valid  <= n_pix_valid | n_done;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: load only with a new word, hold while stalled
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pix_valid <= n_pix_valid;
            r_pix_col   <= n_pix_col;
            r_pix_line  <= n_pix_line;
            r_pix_val   <= n_pix_val;
            r_done      <= n_done;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_valid  = r_pix_valid;
    assign o_pixel_column = r_pix_col;
    assign o_pixel_line   = r_pix_line;
    assign o_pixel_value  = r_pix_val;
    assign o_frame_done   = r_done;

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for tree_mask_delta_decoder
// Feeds packed frame-delta streams byte by byte. This covers well-formed
// frames with random masks, truncated frames, raw noise bursts and several
// line count settings. A local decoder predicts every result word, and each
// word leaving the block is compared against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import tmdd_pkg::*;

    // Decoder position within a frame, mirrored by the predictor
    typedef enum logic [2:0] {
        PH_TOP_LO,
        PH_TOP_HI,
        PH_MID,
        PH_LEAF,
        PH_PIX
    } t_decode_phase;

    // One result word as it leaves the block
    typedef struct packed {
        logic               pix_valid;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] line;
        t_byte              value;
        logic               done;
    } t_pixel_write;

    logic               i_clk;
    logic               rst_n;
    logic               in_valid;
    t_byte              in_byte;
    logic               out_stall;
    logic               cfg_valid;
    logic [LCNT_W-1:0]  cfg_data;

    logic               in_stall;
    logic               out_valid;
    logic               px_valid;
    logic [COORD_W-1:0] px_column;
    logic [COORD_W-1:0] px_line;
    t_byte              px_value;
    logic               frame_done;
    logic               cfg_ready;

    // Predictor state: mirrors the masks and indexes held inside the block
    t_decode_phase      dec_phase;
    logic [TOP_W-1:0]   dec_top;
    logic [3:0]         dec_top_idx;
    t_byte              dec_mid;
    logic [2:0]         dec_mid_idx;
    t_byte              dec_leaf;
    logic [2:0]         dec_leaf_idx;
    logic [1:0]         dec_pix_idx;
    logic [LCNT_W-1:0]  dec_line_count;

    t_pixel_write       pending_writes [$];
    int                 mismatch_count;
    int                 bytes_fed;
    bit                 in_quiet;
    bit                 out_quiet;

    tree_mask_delta_decoder i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_stream_byte  (in_byte),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_pixel_valid  (px_valid),
        .o_pixel_column (px_column),
        .o_pixel_line   (px_line),
        .o_pixel_value  (px_value),
        .o_frame_done   (frame_done),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Advance to the next marked block at or above 'from'; return 1 when the
    // frame runs out of blocks, so the next byte opens a new frame.
    function automatic bit next_block(input int from);
        for (int b = from; b < TOP_BLOCKS; b++) begin
            if (dec_top[b]) begin
                dec_top_idx = 4'(b);
                dec_phase   = PH_MID;
                return 1'b0;
            end
        end
        dec_phase = PH_TOP_LO;
        return 1'b1;
    endfunction

    // Advance to the next marked half-line; fall back to the next block
    function automatic bit next_half(input int from);
        for (int m = from; m < 8; m++) begin
            if (dec_mid[m]) begin
                dec_mid_idx = 3'(m);
                dec_phase   = PH_LEAF;
                return 1'b0;
            end
        end
        return next_block(int'(dec_top_idx) + 1);
    endfunction

    // Advance to the next marked pixel group; fall back to the next half-line
    function automatic bit next_group(input int from);
        for (int g = from; g < 8; g++) begin
            if (dec_leaf[g]) begin
                dec_leaf_idx = 3'(g);
                dec_pix_idx  = '0;
                dec_phase    = PH_PIX;
                return 1'b0;
            end
        end
        return next_half(int'(dec_mid_idx) + 1);
    endfunction

    function automatic void reset_decoder();
        dec_phase      = PH_TOP_LO;
        dec_top        = '0;
        dec_top_idx    = '0;
        dec_mid        = '0;
        dec_mid_idx    = '0;
        dec_leaf       = '0;
        dec_leaf_idx   = '0;
        dec_pix_idx    = '0;
        dec_line_count = LINE_COUNT_RST;
    endfunction

    // Consume one stream byte and queue the word it should produce, if any
    function automatic void decode_byte(input t_byte b);
        t_pixel_write w;
        int           line;
        int           col;
        w = '0;
        case (dec_phase)
            PH_TOP_HI: begin
                dec_top[15:8] = b;
                w.done = next_block(0);
            end
            PH_MID: begin
                dec_mid = b;
                w.done = next_half(0);
            end
            PH_LEAF: begin
                dec_leaf = b;
                w.done = next_group(0);
            end
            PH_PIX: begin
                line = int'(dec_top_idx) * 4 + int'(dec_mid_idx) / 2;
                col  = int'(dec_mid_idx[0]) * 32 + int'(dec_leaf_idx) * 4
                       + int'(dec_pix_idx);
                // Pixels past the line count are consumed but never written
                if (line < int'(dec_line_count)) begin
                    w.pix_valid = 1'b1;
                    w.line      = COORD_W'(line);
                    w.col       = COORD_W'(col);
                    w.value     = b;
                end
                if (dec_pix_idx == 2'd3) begin
                    w.done = next_group(int'(dec_leaf_idx) + 1);
                end else begin
                    dec_pix_idx = dec_pix_idx + 2'd1;
                end
            end
            default: begin
                dec_top   = {8'h00, b};
                dec_phase = PH_TOP_HI;
            end
        endcase
        if (w.pix_valid || w.done) begin
            pending_writes.push_back(w);
        end
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stall per word, check every accepted word
    // ------------------------------------------------------------------

    // Sample at the falling edge: everything driven at the rising edge has
    // settled, and a word seen here with stall low is taken at the next edge.
    task automatic check_word();
        t_pixel_write got;
        t_pixel_write want;
        got = {px_valid, px_column, px_line, px_value, frame_done};
        if (pending_writes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("unexpected word: valid=%0d col=%0d line=%0d value=%02h done=%0d",
                         got.pix_valid, got.col, got.line, got.value, got.done);
            end
        end else begin
            want = pending_writes.pop_front();
            if (got.pix_valid !== want.pix_valid || got.col !== want.col ||
                got.line !== want.line || got.value !== want.value ||
                got.done !== want.done) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("word mismatch: expected valid=%0d col=%0d line=%0d value=%02h done=%0d",
                             want.pix_valid, want.col, want.line, want.value, want.done);
                    $display("                  actual valid=%0d col=%0d line=%0d value=%02h done=%0d",
                             got.pix_valid, got.col, got.line, got.value, got.done);
                end
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (rst_n && out_valid && !out_stall) begin
            check_word();
        end
    end

    // Draw a stall length for every word; hold stall low once it runs out
    initial begin : result_stall
        int hold;
        wait (rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            hold = out_quiet ? 0 : $urandom_range(0, 6);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                out_stall <= 1'b0;
            end
            do @(negedge i_clk); while (!out_valid);
            @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // Stream side
    // ------------------------------------------------------------------

    // Send one byte after a random gap; hold it until the block takes it.
    // Leave valid high on return so a back-to-back byte keeps it raised.
    task automatic send_byte(input t_byte b);
        int gap;
        gap = in_quiet ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do @(negedge i_clk); while (in_stall);
        @(posedge i_clk);
        decode_byte(b);
        bytes_fed++;
    endtask

    // Drop valid and wait until every predicted word has left the block
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge i_clk);
        // Mask bytes give no word; let the last of them clear the pipeline
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_line_count(input logic [LCNT_W-1:0] value);
        wait_results_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(negedge i_clk); while (!cfg_ready);
        @(posedge i_clk);
        cfg_valid <= 1'b0;
        dec_line_count = value;
    endtask

    function automatic t_byte sparse_byte(input int pct);
        t_byte m;
        for (int i = 0; i < 8; i++) begin
            m[i] = ($urandom_range(0, 99) < pct);
        end
        return m;
    endfunction

    // Finish whatever frame the decoder is in: zero masks skip forward and
    // zero pixels run out their group, so this always reaches a frame end.
    task automatic align_to_frame();
        while (dec_phase != PH_TOP_LO) begin
            send_byte(8'h00);
        end
    endtask

    // Send one well-formed frame with random masks below the given top mask
    task automatic send_frame(input logic [TOP_W-1:0] top, input int mid_pct,
                              input int leaf_pct);
        t_byte mid;
        t_byte leaf;
        send_byte(top[7:0]);
        send_byte(top[15:8]);
        for (int b = 0; b < TOP_BLOCKS; b++) begin
            if (top[b]) begin
                mid = sparse_byte(mid_pct);
                send_byte(mid);
                for (int m = 0; m < 8; m++) begin
                    if (mid[m]) begin
                        leaf = sparse_byte(leaf_pct);
                        send_byte(leaf);
                        for (int g = 0; g < 8; g++) begin
                            if (leaf[g]) begin
                                repeat (4) send_byte(t_byte'($urandom_range(0, 255)));
                            end
                        end
                    end
                end
            end
        end
    endtask

    function automatic logic [LCNT_W-1:0] random_line_count();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            return '0;
        end else if (pick == 1) begin
            return LCNT_W'($urandom_range(65, 127));
        end
        return LCNT_W'($urandom_range(1, 64));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-built frames at the reset line count of 51
    task automatic test_directed_frames();
        t_byte seq [23];
        seq = '{
            // all-zero top mask: frame ends on the second byte
            8'h00, 8'h00,
            // only the unused top bits set: same as an empty frame
            8'h00, 8'hE0,
            // blocks 0 and 12; block 0 has an empty mid mask, block 12 marks
            // line 48 (group 7, extreme pixel values) and line 51, whose
            // empty leaf mask closes the frame
            8'h01, 8'h10, 8'h00, 8'h81, 8'h80,
            8'h00, 8'hFF, 8'h01, 8'h80, 8'h00,
            // block 1: empty leaf mask mid-frame, then one group; the last
            // pixel carries the frame end together with its write
            8'h02, 8'h00, 8'h03, 8'h00, 8'h01,
            8'h7F, 8'hFE, 8'hAA, 8'h55
        };
        foreach (seq[i]) begin
            send_byte(seq[i]);
        end
    endtask

    // Sweep the line count through its extremes, touching every block
    task automatic test_line_count_limits();
        logic [LCNT_W-1:0] settings [6];
        settings = '{7'd0, 7'd1, 7'd64, 7'd127, 7'd65, 7'd33};
        foreach (settings[i]) begin
            write_line_count(settings[i]);
            send_frame(16'hFFFF, 10, 20);
            send_frame({sparse_byte(30), sparse_byte(30)}, 30, 30);
        end
    endtask

    // Mostly well-formed frames with random content, some raw noise, line
    // count changes and full drains in between; run until the whole bench
    // has fed about 1800 bytes
    task automatic test_random_stream();
        int pick;
        int pct;
        while (bytes_fed < 1800) begin
            // Switch idling on and off now and then for stretches at full rate
            if ($urandom_range(0, 9) == 0) in_quiet = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 9) == 0) out_quiet = ($urandom_range(0, 2) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 76) begin
                pct = $urandom_range(5, 40);
                align_to_frame();
                send_frame({sparse_byte(pct), sparse_byte(pct)},
                           $urandom_range(10, 45), $urandom_range(10, 45));
            end else if (pick < 90) begin
                // Noise lands in whatever phase the decoder is in
                repeat ($urandom_range(1, 12)) send_byte(t_byte'($urandom_range(0, 255)));
            end else if (pick < 95) begin
                write_line_count(random_line_count());
            end else begin
                wait_results_drained();
            end
        end
        in_quiet  = 1'b0;
        out_quiet = 1'b0;
    endtask

    initial begin
        i_clk          = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_byte        = '0;
        out_stall      = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        mismatch_count = 0;
        bytes_fed      = 0;
        in_quiet       = 1'b0;
        out_quiet      = 1'b0;
        reset_decoder();

        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;

        test_directed_frames();
        test_line_count_limits();
        test_random_stream();

        wait_results_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
